### sv/tte_pkg.sv
// Shared constants, types and the microcode table of the tap tempo estimator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tte_pkg;

   // Ring geometry
   localparam int TAP_SLOTS   = 8;
   localparam int POS_W       = $clog2(TAP_SLOTS);
   localparam int TAPS_W      = $clog2(TAP_SLOTS + 1);

   // Field widths
   localparam int TEMPO_W     = 14;
   localparam int COUNT_W     = 4;
   localparam int TIME_W      = 16;
   localparam int DELTA_W     = 12;
   localparam int GAP_STORE_W = 12;
   localparam int SUM_W       = $clog2(TAP_SLOTS * (2 ** GAP_STORE_W));

   // Divider: 20-bit dividend, two quotient bits per cycle
   localparam int DIV_W       = 20;
   localparam int DIV_STEPS   = DIV_W / 2;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
   localparam int CLAMP_W     = DIV_W + 1;

   // Constants of the algorithm
   localparam int TEMPO_NUMERATOR = 600000;
   localparam int TEMPO_RESET     = 1200;
   localparam int MIN_RESET       = 300;
   localparam int MAX_RESET       = 3000;
   localparam int RESTART_GAP_MS  = 3000;
   localparam int MIN_GAP_MS      = 100;
   localparam int TAPS_FOR_TEMPO  = 4;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;

   localparam logic [CSR_IDX_W-1:0] CSR_EDIT_ENABLED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TEMPO    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TEMPO    = 2'd2;

   // Item kinds
   localparam logic ACTION_TAP    = 1'b0;
   localparam logic ACTION_ADJUST = 1'b1;

   typedef logic [TEMPO_W-1:0] tempo_type;

   // Datapath operations
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LATCH,
      OP_GAP,
      OP_SET_LAST,
      OP_PUSH,
      OP_SUM_INIT,
      OP_SUM_ADD,
      OP_DIV_AVG,
      OP_DIV_TEMPO,
      OP_SET_TEMPO,
      OP_START_RUN,
      OP_CLEAR_RUN,
      OP_ADJUST,
      OP_EMIT
   } dp_op_type;

   // Jump conditions
   typedef enum logic [3:0] {
      C_NEXT,
      C_ALWAYS,
      C_NO_ITEM,
      C_IS_ADJUST,
      C_EDIT_OFF,
      C_RESTART,
      C_SHORT_GAP,
      C_FEW_TAPS,
      C_SUM_MORE,
      C_DIV_BUSY,
      C_RSP_BUSY
   } cond_type;

   // Program addresses
   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_GAP,
      S_RUN_CHECK,
      S_GAP_CHECK,
      S_PUSH,
      S_SUM_INIT,
      S_SUM_LOOP,
      S_DIV_AVG,
      S_WAIT_AVG,
      S_DIV_TEMPO,
      S_WAIT_TEMPO,
      S_SET_TEMPO,
      S_START_RUN,
      S_CLEAR_RUN,
      S_ADJ_CHECK,
      S_ADJUST,
      S_WAIT_RSP,
      S_EMIT
   } step_type;

   typedef struct packed {
      dp_op_type op;
      cond_type  cond;
      step_type  target;
   } ctrl_type;

   typedef struct packed {
      logic is_adjust;
      logic edit_off;
      logic restart;
      logic short_gap;
      logic few_taps;
      logic sum_more;
   } dp_status_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [SUM_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   function automatic ctrl_type uword(dp_op_type op, cond_type cond, step_type target);
      ctrl_type w;
      w.op     = op;
      w.cond   = cond;
      w.target = target;
      return w;
   endfunction

   // Microcode: operation, jump condition, jump target (else fall through)
   function automatic ctrl_type ucode_word(step_type s);
      ctrl_type w;
      unique case (s)
         S_IDLE:       w = uword(OP_LATCH,     C_NO_ITEM,   S_IDLE);
         S_DISPATCH:   w = uword(OP_NOP,       C_IS_ADJUST, S_ADJ_CHECK);
         S_GAP:        w = uword(OP_GAP,       C_EDIT_OFF,  S_CLEAR_RUN);
         S_RUN_CHECK:  w = uword(OP_NOP,       C_RESTART,   S_START_RUN);
         S_GAP_CHECK:  w = uword(OP_SET_LAST,  C_SHORT_GAP, S_WAIT_RSP);
         S_PUSH:       w = uword(OP_PUSH,      C_NEXT,      S_IDLE);
         S_SUM_INIT:   w = uword(OP_SUM_INIT,  C_FEW_TAPS,  S_WAIT_RSP);
         S_SUM_LOOP:   w = uword(OP_SUM_ADD,   C_SUM_MORE,  S_SUM_LOOP);
         S_DIV_AVG:    w = uword(OP_DIV_AVG,   C_NEXT,      S_IDLE);
         S_WAIT_AVG:   w = uword(OP_NOP,       C_DIV_BUSY,  S_WAIT_AVG);
         S_DIV_TEMPO:  w = uword(OP_DIV_TEMPO, C_NEXT,      S_IDLE);
         S_WAIT_TEMPO: w = uword(OP_NOP,       C_DIV_BUSY,  S_WAIT_TEMPO);
         S_SET_TEMPO:  w = uword(OP_SET_TEMPO, C_ALWAYS,    S_WAIT_RSP);
         S_START_RUN:  w = uword(OP_START_RUN, C_ALWAYS,    S_WAIT_RSP);
         S_CLEAR_RUN:  w = uword(OP_CLEAR_RUN, C_ALWAYS,    S_WAIT_RSP);
         S_ADJ_CHECK:  w = uword(OP_NOP,       C_EDIT_OFF,  S_WAIT_RSP);
         S_ADJUST:     w = uword(OP_ADJUST,    C_NEXT,      S_IDLE);
         S_WAIT_RSP:   w = uword(OP_NOP,       C_RSP_BUSY,  S_WAIT_RSP);
         S_EMIT:       w = uword(OP_EMIT,      C_ALWAYS,    S_IDLE);
         default:      w = uword(OP_NOP,       C_ALWAYS,    S_IDLE);
      endcase
      return w;
   endfunction

   // Lower limit first, upper limit second
   function automatic tempo_type clamp_tempo(logic signed [CLAMP_W-1:0] t,
                                             tempo_type lo, tempo_type hi);
      logic signed [CLAMP_W-1:0] r;
      logic signed [CLAMP_W-1:0] lo_s;
      logic signed [CLAMP_W-1:0] hi_s;
      lo_s = $signed(CLAMP_W'(lo));
      hi_s = $signed(CLAMP_W'(hi));
      r    = t;
      if (r < lo_s) r = lo_s;
      if (r > hi_s) r = hi_s;
      return r[TEMPO_W-1:0];
   endfunction

endpackage

`default_nettype wire

### sv/tte_ifs.sv
// Valid/ready channel interfaces for tap/adjust items and tempo results.
// Depends on tte_pkg for field widths.
`default_nettype none

interface tte_req_if import tte_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      action;
   logic [TIME_W-1:0]         time_ms;
   logic signed [DELTA_W-1:0] tempo_step;

   modport source (output valid, action, time_ms, tempo_step, input ready);
   modport sink   (input valid, action, time_ms, tempo_step, output ready);
endinterface

interface tte_rsp_if import tte_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [TEMPO_W-1:0] tempo_x10;
   logic [COUNT_W-1:0] tap_count;
   logic               tempo_changed;

   modport source (output valid, tempo_x10, tap_count, tempo_changed, input ready);
   modport sink   (input valid, tempo_x10, tap_count, tempo_changed, output ready);
endinterface

`default_nettype wire

### sv/tte_divider.sv
// Iterative restoring divider, two quotient bits per cycle.
// Depends on tte_pkg for widths and the request/response structs.
`default_nettype none

module tte_divider import tte_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [SUM_W-1:0]     dvs_ff, dvs_in;

   // One shift/compare/subtract step: returns {remainder, quotient}
   function automatic logic [SUM_W+DIV_W-1:0] div_step(logic [SUM_W-1:0] r,
                                                       logic [DIV_W-1:0] q,
                                                       logic [SUM_W-1:0] d);
      logic [SUM_W:0]   sh;
      logic [DIV_W-1:0] qn;
      sh = {r, q[DIV_W-1]};
      qn = {q[DIV_W-2:0], 1'b0};
      if (sh >= {1'b0, d}) begin
         sh    = sh - {1'b0, d};
         qn[0] = 1'b1;
      end
      return {sh[SUM_W-1:0], qn};
   endfunction

   // Load on start, else two steps while the count runs
   always_comb begin
      logic [SUM_W+DIV_W-1:0] s1;
      logic [SUM_W+DIV_W-1:0] s2;
      s1     = div_step(rem_ff, quo_ff, dvs_ff);
      s2     = div_step(s1[SUM_W+DIV_W-1:DIV_W], s1[DIV_W-1:0], dvs_ff);
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      if (div_req.start) begin
         cnt_in = DIV_CNT_W'(DIV_STEPS);
         rem_in = '0;
         quo_in = div_req.dividend;
         dvs_in = div_req.divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         rem_in = s2[SUM_W+DIV_W-1:DIV_W];
         quo_in = s2[DIV_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.busy     = (cnt_ff != '0);
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

### sv/tte_sequencer.sv
// Microcode sequencer: step counter, control word fetch and conditional jumps.
// Depends on tte_pkg for the microcode table and the control/status structs.
`default_nettype none

module tte_sequencer import tte_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   input  logic          rsp_busy,
   input  logic          div_busy,
   input  dp_status_type status,
   output ctrl_type      ctrl,
   output logic          idle
);

   step_type step_ff, step_in;
   logic     take_jump;

   // Control word of the current step
   assign ctrl = ucode_word(step_ff);
   assign idle = (step_ff == S_IDLE);

   // Condition select
   always_comb begin
      unique case (ctrl.cond)
         C_NEXT:      take_jump = 1'b0;
         C_ALWAYS:    take_jump = 1'b1;
         C_NO_ITEM:   take_jump = !item_valid;
         C_IS_ADJUST: take_jump = status.is_adjust;
         C_EDIT_OFF:  take_jump = status.edit_off;
         C_RESTART:   take_jump = status.restart;
         C_SHORT_GAP: take_jump = status.short_gap;
         C_FEW_TAPS:  take_jump = status.few_taps;
         C_SUM_MORE:  take_jump = status.sum_more;
         C_DIV_BUSY:  take_jump = div_busy;
         C_RSP_BUSY:  take_jump = rsp_busy;
         default:     take_jump = 1'b1;
      endcase
   end

   // Next step
   always_comb begin
      if (take_jump) begin
         step_in = ctrl.target;
      end else begin
         step_in = step_type'(step_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= S_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

`default_nettype wire

### sv/tte_datapath.sv
// Datapath: tempo, run state, interval ring, accumulator and setting registers.
// Depends on tte_pkg; driven by the sequencer's control word.
`default_nettype none

module tte_datapath import tte_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  ctrl_type                  ctrl,
   input  logic                      item_action,
   input  logic [TIME_W-1:0]         item_time_ms,
   input  logic signed [DELTA_W-1:0] item_delta,
   input  logic                      cfg_we,
   input  logic [CSR_IDX_W-1:0]      cfg_index,
   input  logic [CSR_DATA_W-1:0]     cfg_wdata,
   input  div_rsp_type               div_rsp,
   output div_req_type               div_req,
   output dp_status_type             status,
   output tempo_type                 tempo,
   output logic [TAPS_W-1:0]         taps,
   output logic                      changed
);

   // Settings
   logic      edit_ff, edit_in;
   tempo_type min_ff, min_in;
   tempo_type max_ff, max_in;

   // Run state
   tempo_type              tempo_ff, tempo_in;
   logic [TAPS_W-1:0]      taps_ff, taps_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [TIME_W-1:0]      last_ff, last_in;
   logic [GAP_STORE_W-1:0] ring_ff [TAP_SLOTS];
   logic [GAP_STORE_W-1:0] ring_in [TAP_SLOTS];
   logic                   changed_ff, changed_in;

   // Working registers
   logic                      act_ff, act_in;
   logic [TIME_W-1:0]         time_ff, time_in;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic [TIME_W-1:0]         gap_ff, gap_in;
   logic [SUM_W-1:0]          acc_ff, acc_in;
   logic [POS_W-1:0]          idx_ff, idx_in;
   logic                      avg_zero_ff, avg_zero_in;

   // Operation decode
   always_comb begin
      tempo_in    = tempo_ff;
      taps_in     = taps_ff;
      pos_in      = pos_ff;
      last_in     = last_ff;
      ring_in     = ring_ff;
      changed_in  = changed_ff;
      act_in      = act_ff;
      time_in     = time_ff;
      delta_in    = delta_ff;
      gap_in      = gap_ff;
      acc_in      = acc_ff;
      idx_in      = idx_ff;
      avg_zero_in = avg_zero_ff;
      unique case (ctrl.op)
         OP_LATCH: begin
            act_in     = item_action;
            time_in    = item_time_ms;
            delta_in   = item_delta;
            changed_in = 1'b0;
         end
         OP_GAP: begin
            gap_in = time_ff - last_ff;
         end
         OP_SET_LAST: begin
            last_in = time_ff;
         end
         OP_PUSH: begin
            ring_in[pos_ff] = gap_ff[GAP_STORE_W-1:0];
            pos_in  = (pos_ff == POS_W'(TAP_SLOTS - 1)) ? '0 : pos_ff + 1'b1;
            if (taps_ff < TAPS_W'(TAP_SLOTS)) taps_in = taps_ff + 1'b1;
            last_in = time_ff;
         end
         OP_SUM_INIT: begin
            acc_in = '0;
            idx_in = '0;
         end
         OP_SUM_ADD: begin
            acc_in = acc_ff + SUM_W'(ring_ff[idx_ff]);
            idx_in = idx_ff + 1'b1;
         end
         OP_DIV_TEMPO: begin
            avg_zero_in = (div_rsp.quotient == '0);
         end
         OP_SET_TEMPO: begin
            tempo_in   = clamp_tempo(avg_zero_ff ? CLAMP_W'(tempo_ff)
                                                 : CLAMP_W'(div_rsp.quotient),
                                     min_ff, max_ff);
            changed_in = 1'b1;
         end
         OP_START_RUN: begin
            for (int i = 0; i < TAP_SLOTS; i++) ring_in[i] = '0;
            taps_in = TAPS_W'(1);
            pos_in  = '0;
            last_in = time_ff;
         end
         OP_CLEAR_RUN: begin
            for (int i = 0; i < TAP_SLOTS; i++) ring_in[i] = '0;
            taps_in = '0;
            pos_in  = '0;
            last_in = '0;
         end
         OP_ADJUST: begin
            tempo_in   = clamp_tempo(CLAMP_W'($signed({1'b0, tempo_ff}))
                                     + CLAMP_W'(delta_ff), min_ff, max_ff);
            changed_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Setting writes
   always_comb begin
      edit_in = edit_ff;
      min_in  = min_ff;
      max_in  = max_ff;
      if (cfg_we) begin
         case (cfg_index)
            CSR_EDIT_ENABLED: edit_in = cfg_wdata[0];
            CSR_MIN_TEMPO:    min_in  = cfg_wdata[TEMPO_W-1:0];
            CSR_MAX_TEMPO:    max_in  = cfg_wdata[TEMPO_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edit_ff    <= 1'b1;
         min_ff     <= TEMPO_W'(MIN_RESET);
         max_ff     <= TEMPO_W'(MAX_RESET);
         tempo_ff   <= TEMPO_W'(TEMPO_RESET);
         taps_ff    <= '0;
         pos_ff     <= '0;
         last_ff    <= '0;
         changed_ff <= 1'b0;
         for (int i = 0; i < TAP_SLOTS; i++) ring_ff[i] <= '0;
      end else begin
         edit_ff    <= edit_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
         tempo_ff   <= tempo_in;
         taps_ff    <= taps_in;
         pos_ff     <= pos_in;
         last_ff    <= last_in;
         changed_ff <= changed_in;
         ring_ff    <= ring_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      time_ff     <= time_in;
      delta_ff    <= delta_in;
      gap_ff      <= gap_in;
      acc_ff      <= acc_in;
      idx_ff      <= idx_in;
      avg_zero_ff <= avg_zero_in;
   end

   // Divider operands: sum / (taps - 1), then numerator / average
   always_comb begin
      div_req.start    = (ctrl.op == OP_DIV_AVG) || (ctrl.op == OP_DIV_TEMPO);
      div_req.dividend = (ctrl.op == OP_DIV_TEMPO) ? DIV_W'(TEMPO_NUMERATOR)
                                                   : DIV_W'(acc_ff);
      div_req.divisor  = (ctrl.op == OP_DIV_TEMPO) ? div_rsp.quotient[SUM_W-1:0]
                                                   : SUM_W'(taps_ff - 1'b1);
   end

   // Branch flags
   always_comb begin
      status.is_adjust = (act_ff == ACTION_ADJUST);
      status.edit_off  = !edit_ff;
      status.restart   = (taps_ff == '0) || (gap_ff > TIME_W'(RESTART_GAP_MS));
      status.short_gap = (gap_ff < TIME_W'(MIN_GAP_MS));
      status.few_taps  = (int'(taps_ff) < TAPS_FOR_TEMPO);
      status.sum_more  = ((int'(idx_ff) + 2) < int'(taps_ff));
   end

   assign tempo   = tempo_ff;
   assign taps    = taps_ff;
   assign changed = changed_ff;

endmodule

`default_nettype wire

### sv/tap_tempo_estimator.sv
// Tap tempo estimator top: sequencer, datapath, divider and result register.
// Depends on tte_pkg and the channel interfaces in tte_ifs.sv.
// Path from accepting edge to result: adjusts and taps that set no tempo skip the divider;
// a tap that sets it runs the ring sum and two divider passes first. One item at a time:
// ready returns with the result; a waiting result stalls the next item's emit.
// Reset (sync): tempo 120.0 BPM, run cleared, limits 30-300 BPM.
`default_nettype none

module tap_tempo_estimator import tte_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   tte_req_if.sink               req_bus,
   tte_rsp_if.source             rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   ctrl_type          ctrl;
   dp_status_type     status;
   div_req_type       div_req;
   div_rsp_type       div_rsp;
   logic              idle;
   tempo_type         tempo;
   logic [TAPS_W-1:0] taps;
   logic              changed;

   logic               rsp_valid_ff, rsp_valid_in;
   tempo_type          rsp_tempo_ff, rsp_tempo_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_changed_ff, rsp_changed_in;

   tte_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_bus.valid),
      .rsp_busy   (rsp_valid_ff && !rsp_bus.ready),
      .div_busy   (div_rsp.busy),
      .status     (status),
      .ctrl       (ctrl),
      .idle       (idle)
   );

   tte_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .item_action  (req_bus.action),
      .item_time_ms (req_bus.time_ms),
      .item_delta   (req_bus.tempo_step),
      .cfg_we       (csr_we),
      .cfg_index    (csr_index),
      .cfg_wdata    (csr_wdata),
      .div_rsp      (div_rsp),
      .div_req      (div_req),
      .status       (status),
      .tempo        (tempo),
      .taps         (taps),
      .changed      (changed)
   );

   tte_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_bus.ready = idle;

   // Result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_tempo_in   = rsp_tempo_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_changed_in = rsp_changed_ff;
      if (rsp_valid_ff && rsp_bus.ready) rsp_valid_in = 1'b0;
      if (ctrl.op == OP_EMIT) begin
         rsp_valid_in   = 1'b1;
         rsp_tempo_in   = tempo;
         rsp_count_in   = COUNT_W'(taps);
         rsp_changed_in = changed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_tempo_ff   <= rsp_tempo_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_changed_ff <= rsp_changed_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.tempo_x10     = rsp_tempo_ff;
   assign rsp_bus.tap_count     = rsp_count_ff;
   assign rsp_bus.tempo_changed = rsp_changed_ff;

endmodule

`default_nettype wire
